[sv/qbr_pkg.sv]
package qbr_pkg;

    // defaults for the top-level parameters
    localparam int DEF_OUT_FRAMES  = 128;
    localparam int DEF_MAX_SRC     = 512;
    localparam int DEF_SAMPLE_BITS = 16;

    // block length register
    localparam int              CFG_W          = 10;
    localparam logic [CFG_W-1:0] SRC_FRAMES_RST = CFG_W'(128);
    localparam int              MIN_FRAMES     = 3;

    // fixed point of the offset (Q7) and of the sum (Q14)
    localparam int FRAC_BITS = 7;
    localparam int ACC_FRAC  = 2 * FRAC_BITS;
    localparam int D_W       = FRAC_BITS + 2;
    // squared offset, kept signed
    localparam int DD_W      = 2 * D_W;

    // request kinds
    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_PRODUCE = 1'b1;

    // result status
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_POS,
        S_DIV,
        S_CLAMP,
        S_RDM,
        S_RD0,
        S_RD1,
        S_RD2,
        S_COEF,
        S_MA,
        S_MB,
        S_ACC,
        S_FIN,
        S_DONE
    } t_state;

endpackage

[sv/qbr_req_if.sv]
interface qbr_req_if #(
    parameter int SAMPLE_BITS = qbr_pkg::DEF_SAMPLE_BITS
);
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;

    modport source (output valid, kind, left_in, right_in, input ready);
    modport sink (input valid, kind, left_in, right_in, output ready);
endinterface

[sv/qbr_rsp_if.sv]
interface qbr_rsp_if #(
    parameter int SAMPLE_BITS = qbr_pkg::DEF_SAMPLE_BITS
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic                          last;
    logic                          status;

    modport source (output valid, left_out, right_out, last, status, input ready);
    modport sink (input valid, left_out, right_out, last, status, output ready);
endinterface

[sv/quadratic_block_resampler.sv]
// Stereo block resampler with quadratic interpolation. Load requests (kind 0) write one
// source frame each into the frame store until src_frames frames are held; produce
// requests (kind 1) then return OUT_FRAMES interpolated frames, the last one flagged,
// after which the block starts collecting a fresh source block. A produce request made
// before the block is full returns zero samples with status set and keeps the block
// busy. A produce request on a full block keeps the block busy while the output
// position is divided by OUT_FRAMES through a multiply by a constant reciprocal, then
// three frame store reads and the squared offset follow, and the two channels are
// interpolated one after the other, each through S_COEF, S_MA, S_MB, S_ACC and S_FIN.
// Seven multiplies in all pass through the single shared multiplier, and the reads
// through the one-port store read. The result sits in an output register, so a new
// request is taken while the previous result still waits to be collected; a produce
// request that finishes while that register is still full waits until it is collected.
module quadratic_block_resampler #(
    parameter int OUT_FRAMES  = qbr_pkg::DEF_OUT_FRAMES,
    parameter int MAX_SRC     = qbr_pkg::DEF_MAX_SRC,
    parameter int SAMPLE_BITS = qbr_pkg::DEF_SAMPLE_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [qbr_pkg::CFG_W-1:0]  i_cfg_wr_data,
    qbr_req_if.sink                    i_req,
    qbr_rsp_if.source                  o_rsp
);
    import qbr_pkg::*;

    localparam int SB   = SAMPLE_BITS;
    localparam int AW   = $clog2(MAX_SRC);
    localparam int FW   = $clog2(MAX_SRC + 1);
    localparam int CW   = (FW > CFG_W) ? FW : CFG_W;
    localparam int IW   = $clog2(OUT_FRAMES);
    localparam int PW   = IW + FW;
    localparam int DW   = PW + FRAC_BITS;
    localparam int QW   = FW + FRAC_BITS;
    localparam int MW   = DW + 1;
    localparam int RSH  = DW + IW;
    localparam int XW0  = (SB > FW + 1) ? SB : FW + 1;
    localparam int XW   = (XW0 > DW + 1) ? XW0 : DW + 1;
    localparam int YW0  = (DD_W > IW + 1) ? DD_W : IW + 1;
    localparam int YW   = (YW0 > MW + 1) ? YW0 : MW + 1;
    localparam int PRW  = XW + YW;
    localparam int ACW  = SB + DD_W;
    localparam int YQW  = ACW - ACC_FRAC;

    // reciprocal of the output frame count, exact for any dividend below 2**DW
    localparam longint RECIP_L = ((longint'(1) << RSH) + longint'(OUT_FRAMES) - 1)
                                 / longint'(OUT_FRAMES);

    localparam logic [MW-1:0]         RECIP_M  = MW'(RECIP_L);
    localparam logic [IW-1:0]         LAST_IDX = IW'(OUT_FRAMES - 1);
    localparam logic [CW-1:0]         N_MIN    = CW'(MIN_FRAMES);
    localparam logic [CW-1:0]         N_MAX    = CW'(MAX_SRC);
    localparam logic signed [ACW-1:0] ACC_BIAS = ACW'((1 << ACC_FRAC) - 1);
    localparam logic signed [YQW-1:0] Y_MAX    = YQW'((1 << (SB - 1)) - 1);
    localparam logic signed [YQW-1:0] Y_MIN    = -Y_MAX - YQW'(1);

    // registers
    t_state                  r_state, n_state;
    logic [CFG_W-1:0]        r_src_frames, n_src_frames;
    logic [FW-1:0]           r_frames_loaded, n_frames_loaded;
    logic [IW-1:0]           r_out_index, n_out_index;
    logic                    r_out_valid, n_out_valid;
    logic signed [SB-1:0]    r_out_left, n_out_left;
    logic signed [SB-1:0]    r_out_right, n_out_right;
    logic                    r_out_last, n_out_last;
    logic                    r_out_status, n_out_status;
    logic                    r_bad, n_bad;
    logic [DW-1:0]           r_dvd, n_dvd;
    logic [AW-1:0]           r_j, n_j;
    logic signed [D_W-1:0]   r_d, n_d;
    logic signed [YW-1:0]    r_dd, n_dd;
    logic [2*SB-1:0]         r_sm1, n_sm1;
    logic [2*SB-1:0]         r_s0, n_s0;
    logic [2*SB-1:0]         r_s1, n_s1;
    logic                    r_ch, n_ch;
    logic signed [SB-1:0]    r_a, n_a;
    logic signed [SB-1:0]    r_b, n_b;
    logic signed [ACW-1:0]   r_acc, n_acc;
    logic signed [PRW-1:0]   r_prod, n_prod;
    logic signed [SB-1:0]    r_res_l, n_res_l;
    logic signed [SB-1:0]    r_res_r, n_res_r;

    // combinational helpers
    logic [CW-1:0]           n_wide;
    logic [FW-1:0]           n_frames;
    logic                    accept;
    logic                    block_full;
    logic                    ram_wr_en;
    logic [AW-1:0]           ram_rd_addr;
    logic [2*SB-1:0]         ram_rd_data;
    logic signed [XW-1:0]    mul_x;
    logic signed [YW-1:0]    mul_y;
    logic signed [PRW-1:0]   mul_p;
    logic [QW-1:0]           q_pos;
    logic [FW-1:0]           j_raw;
    logic [FW-1:0]           j_hi;
    logic [FW-1:0]           j_clamp;
    logic [QW-1:0]           q_full;
    logic signed [SB-1:0]    smp_m1;
    logic signed [SB-1:0]    smp_0;
    logic signed [SB-1:0]    smp_1;
    logic signed [SB:0]      dif1;
    logic signed [SB:0]      dif1_r;
    logic signed [SB+1:0]    dif2;
    logic signed [SB+1:0]    dif2_r;
    logic signed [ACW-1:0]   acc_r;
    logic signed [YQW-1:0]   y_q;
    logic signed [SB-1:0]    y_sat;

    // effective block length, clamped to the store size
    always_comb begin
        n_wide = CW'(r_src_frames);
        if (n_wide < N_MIN) begin
            n_wide = N_MIN;
        end
        if (n_wide > N_MAX) begin
            n_wide = N_MAX;
        end
    end
    assign n_frames   = FW'(n_wide);
    assign block_full = (r_frames_loaded >= n_frames);

    assign accept      = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);

    // frame store, left sample in the upper half
    assign ram_wr_en = accept && (i_req.kind == KIND_LOAD) && !block_full;

    qbr_ram #(
        .WIDTH (2 * SB),
        .DEPTH (MAX_SRC)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (r_frames_loaded[AW-1:0]),
        .i_wr_data ({i_req.left_in, i_req.right_in}),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // store read address for the three neighbor frames
    always_comb begin
        case (r_state)
            S_RDM:   ram_rd_addr = r_j - AW'(1);
            S_RD1:   ram_rd_addr = r_j + AW'(1);
            default: ram_rd_addr = r_j;
        endcase
    end

    // shared multiplier operand select
    always_comb begin
        case (r_state)
            S_POS: begin
                mul_x = XW'(n_frames);
                mul_y = YW'(r_out_index);
            end
            S_DIV: begin
                mul_x = XW'(r_dvd);
                mul_y = YW'(RECIP_M);
            end
            S_RDM: begin
                mul_x = XW'(r_d);
                mul_y = YW'(r_d);
            end
            S_MA: begin
                mul_x = XW'(r_a);
                mul_y = YW'(r_d);
            end
            S_MB: begin
                mul_x = XW'(r_b);
                mul_y = r_dd;
            end
            default: begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
    end
    assign mul_p = mul_x * mul_y;

    // scaled position over the output frame count, from the reciprocal product
    assign q_pos = r_prod[RSH +: QW];

    // base index clamp and offset in Q7
    assign j_raw   = q_pos[QW-1:FRAC_BITS];
    assign j_hi    = n_frames - FW'(2);
    assign j_clamp = (j_raw == '0) ? FW'(1) : ((j_raw > j_hi) ? j_hi : j_raw);
    assign q_full  = q_pos - {j_clamp, {FRAC_BITS{1'b0}}};

    // neighbor samples of the channel in work
    assign smp_m1 = r_ch ? $signed(r_sm1[SB-1:0]) : $signed(r_sm1[2*SB-1:SB]);
    assign smp_0  = r_ch ? $signed(r_s0[SB-1:0])  : $signed(r_s0[2*SB-1:SB]);
    assign smp_1  = r_ch ? $signed(r_s1[SB-1:0])  : $signed(r_s1[2*SB-1:SB]);

    // slope and curvature, divided with truncation toward zero
    always_comb begin
        dif1   = (SB+1)'(smp_1) - (SB+1)'(smp_m1);
        dif1_r = dif1 + $signed({{SB{1'b0}}, dif1[SB]});
        dif2   = (SB+2)'(smp_1) - ((SB+2)'(smp_0) <<< 1) + (SB+2)'(smp_m1);
        dif2_r = dif2 + $signed({{SB{1'b0}}, dif2[SB+1], dif2[SB+1]});
    end

    // Q14 sum back to samples, toward zero, then saturate
    always_comb begin
        acc_r = r_acc + (r_acc[ACW-1] ? ACC_BIAS : '0);
        y_q   = acc_r[ACW-1:ACC_FRAC];
        if (y_q > Y_MAX) begin
            y_sat = SB'(Y_MAX);
        end else if (y_q < Y_MIN) begin
            y_sat = SB'(Y_MIN);
        end else begin
            y_sat = SB'(y_q);
        end
    end

    // sequencer next state and datapath
    always_comb begin
        n_state         = r_state;
        n_src_frames    = r_src_frames;
        n_frames_loaded = r_frames_loaded;
        n_out_index     = r_out_index;
        n_out_valid     = r_out_valid;
        n_out_left      = r_out_left;
        n_out_right     = r_out_right;
        n_out_last      = r_out_last;
        n_out_status    = r_out_status;
        n_bad           = r_bad;
        n_dvd           = r_dvd;
        n_j             = r_j;
        n_d             = r_d;
        n_dd            = r_dd;
        n_sm1           = r_sm1;
        n_s0            = r_s0;
        n_s1            = r_s1;
        n_ch            = r_ch;
        n_a             = r_a;
        n_b             = r_b;
        n_acc           = r_acc;
        n_prod          = mul_p;
        n_res_l         = r_res_l;
        n_res_r         = r_res_r;

        if (i_cfg_wr_en) begin
            n_src_frames = i_cfg_wr_data;
        end

        // result taken downstream
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_req.kind == KIND_LOAD) begin
                        if (!block_full) begin
                            n_frames_loaded = r_frames_loaded + FW'(1);
                        end
                    end else if (!block_full) begin
                        n_bad   = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        n_bad   = 1'b0;
                        n_state = S_POS;
                    end
                end
            end
            S_POS: begin
                // position i*n, scaled by 128 for the divide
                n_dvd   = {mul_p[PW-1:0], {FRAC_BITS{1'b0}}};
                n_state = S_DIV;
            end
            S_DIV: begin
                // reciprocal product lands in the product register
                n_state = S_CLAMP;
            end
            S_CLAMP: begin
                n_j     = AW'(j_clamp);
                n_d     = $signed(q_full[D_W-1:0]);
                n_state = S_RDM;
            end
            S_RDM: begin
                n_state = S_RD0;
            end
            S_RD0: begin
                n_sm1   = ram_rd_data;
                n_dd    = YW'(r_prod);
                n_state = S_RD1;
            end
            S_RD1: begin
                n_s0    = ram_rd_data;
                n_state = S_RD2;
            end
            S_RD2: begin
                n_s1    = ram_rd_data;
                n_ch    = 1'b0;
                n_state = S_COEF;
            end
            S_COEF: begin
                n_a     = SB'(dif1_r >>> 1);
                n_b     = SB'(dif2_r >>> 2);
                n_acc   = ACW'(smp_0) <<< ACC_FRAC;
                n_state = S_MA;
            end
            S_MA: begin
                n_state = S_MB;
            end
            S_MB: begin
                n_acc   = r_acc + (ACW'(r_prod) <<< FRAC_BITS);
                n_state = S_ACC;
            end
            S_ACC: begin
                n_acc   = r_acc + ACW'(r_prod);
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_ch) begin
                    n_res_l = y_sat;
                    n_ch    = 1'b1;
                    n_state = S_COEF;
                end else begin
                    n_res_r = y_sat;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    if (r_bad) begin
                        n_out_left   = '0;
                        n_out_right  = '0;
                        n_out_last   = 1'b0;
                        n_out_status = STATUS_EMPTY;
                    end else begin
                        n_out_left   = r_res_l;
                        n_out_right  = r_res_r;
                        n_out_last   = (r_out_index == LAST_IDX);
                        n_out_status = STATUS_OK;
                        if (r_out_index == LAST_IDX) begin
                            n_out_index     = '0;
                            n_frames_loaded = '0;
                        end else begin
                            n_out_index = r_out_index + IW'(1);
                        end
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_frames    <= SRC_FRAMES_RST;
            r_frames_loaded <= '0;
            r_out_index     <= '0;
            r_out_valid     <= 1'b0;
            r_bad           <= 1'b0;
            r_ch            <= 1'b0;
        end else begin
            r_src_frames    <= n_src_frames;
            r_frames_loaded <= n_frames_loaded;
            r_out_index     <= n_out_index;
            r_out_valid     <= n_out_valid;
            r_bad           <= n_bad;
            r_ch            <= n_ch;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_out_left   <= n_out_left;
        r_out_right  <= n_out_right;
        r_out_last   <= n_out_last;
        r_out_status <= n_out_status;
        r_dvd        <= n_dvd;
        r_j          <= n_j;
        r_d          <= n_d;
        r_dd         <= n_dd;
        r_sm1        <= n_sm1;
        r_s0         <= n_s0;
        r_s1         <= n_s1;
        r_a          <= n_a;
        r_b          <= n_b;
        r_acc        <= n_acc;
        r_prod       <= n_prod;
        r_res_l      <= n_res_l;
        r_res_r      <= n_res_r;
    end

    // result port
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.left_out  = r_out_left;
    assign o_rsp.right_out = r_out_right;
    assign o_rsp.last      = r_out_last;
    assign o_rsp.status    = r_out_status;
endmodule

[sv/qbr_ram.sv]
module qbr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // one write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule
